### src/assert_macros.svh
// Assertion macros used by the radio CAD receive controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset.
`define RCAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold, disabled while in reset.
`define RCAD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/rcad_pkg.sv
// Types and constants of the radio CAD receive controller.
package rcad_pkg;

  localparam int NUM_W = 25;
  localparam int DEN_W = 17;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [15:0] COUNT_MASK = 16'hFFFF;

  localparam logic [3:0] OP_POLL       = 4'd0;
  localparam logic [3:0] OP_TX_DONE    = 4'd1;
  localparam logic [3:0] OP_RX_DONE    = 4'd2;
  localparam logic [3:0] OP_TX_TIMEOUT = 4'd3;
  localparam logic [3:0] OP_RX_TIMEOUT = 4'd4;
  localparam logic [3:0] OP_RX_ERROR   = 4'd5;
  localparam logic [3:0] OP_CAD_DONE   = 4'd6;
  localparam logic [3:0] OP_CAD_TIMER  = 4'd7;
  localparam logic [3:0] OP_RX_TIMER   = 4'd8;

  localparam logic [2:0] MODE_LOWPOWER  = 3'd0;
  localparam logic [2:0] MODE_RX        = 3'd1;
  localparam logic [2:0] MODE_RXTIMEOUT = 3'd2;
  localparam logic [2:0] MODE_RXERROR   = 3'd3;
  localparam logic [2:0] MODE_TX        = 3'd4;
  localparam logic [2:0] MODE_TXTIMEOUT = 3'd5;
  localparam logic [2:0] MODE_STARTCAD  = 3'd6;

  typedef struct packed {
    logic [3:0]        opcode;
    logic signed [7:0] rssi_sample;
    logic signed [7:0] snr_sample;
    logic              activity_seen;
  } in_word_t;

  typedef struct packed {
    logic              do_standby;
    logic              do_start_rx;
    logic              do_start_cad;
    logic              do_arm_cad_timer;
    logic              do_restart_rx_timer;
    logic              do_stop_rx_timer;
    logic              do_send;
    logic [2:0]        mode_now;
    logic signed [7:0] rssi_mean;
    logic signed [7:0] snr_mean;
    logic [15:0]       good_rx_total;
    logic [15:0]       tx_total;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_rx;
    logic div_busy;
    logic out_free;
  } ctrl_sts_t;

endpackage

### src/rcad_if.sv
// Valid/ready channel interfaces for input and result words.
interface rcad_in_if;
  logic               valid;
  logic               ready;
  rcad_pkg::in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rcad_out_if;
  logic                valid;
  logic                ready;
  rcad_pkg::out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### src/rcad_div.sv
// Serial restoring divider, signed dividend by unsigned divisor, truncating.
module rcad_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [rcad_pkg::NUM_W-1:0]   dividend,
  input  logic        [rcad_pkg::DEN_W-1:0]   divisor,
  output logic                                busy,
  output logic signed [7:0]                   quotient
);

  logic                          busy_r, busy_nxt;
  logic [rcad_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          neg_r;
  logic [rcad_pkg::NUM_W-1:0]    q_r, q_nxt;
  logic [rcad_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [rcad_pkg::DEN_W-1:0]    div_r;
  logic [rcad_pkg::DEN_W:0]      rem_sh;
  logic [rcad_pkg::DEN_W:0]      diff;
  logic                          ge;
  logic [rcad_pkg::NUM_W-1:0]    mag;

  assign mag    = dividend[rcad_pkg::NUM_W-1] ? (~dividend + rcad_pkg::NUM_W'(1)) : dividend;
  assign rem_sh = {rem_r, q_r[rcad_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, div_r};
  assign ge     = ~diff[rcad_pkg::DEN_W];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = {q_r[rcad_pkg::NUM_W-2:0], ge};
    rem_nxt  = ge ? diff[rcad_pkg::DEN_W-1:0] : rem_sh[rcad_pkg::DEN_W-1:0];
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rcad_pkg::CNT_W'(rcad_pkg::NUM_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - rcad_pkg::CNT_W'(1);
      if (cnt_r == rcad_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[rcad_pkg::NUM_W-1];
      q_r   <= mag;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? $signed(~q_r[7:0] + 8'd1) : $signed(q_r[7:0]);

endmodule

### src/rcad_dp.sv
// Datapath: radio state, flags, running means, counters and result register.
module rcad_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcad_pkg::ctrl_cmd_t  cmd,
  output rcad_pkg::ctrl_sts_t  sts,
  input  rcad_pkg::in_word_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rcad_pkg::out_word_t  out_data
);

  localparam int EXT_W = rcad_pkg::NUM_W - 8;

  rcad_pkg::in_word_t  in_r;
  rcad_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r;

  logic [2:0]          mode_r, mode_nxt;
  logic                cad_hit_r, cad_hit_nxt;
  logic                pending_r, pending_nxt;
  logic                win_over_r, win_over_nxt;
  logic signed [7:0]   rssi_avg_r, rssi_avg_nxt;
  logic signed [7:0]   snr_avg_r, snr_avg_nxt;
  logic [15:0]         good_rx_r, good_rx_nxt;
  logic [15:0]         tx_cnt_r, tx_cnt_nxt;

  logic signed [rcad_pkg::NUM_W-1:0] cnt_ext, rssi_ext, snr_ext;
  logic signed [rcad_pkg::NUM_W-1:0] prod_rssi_r, prod_snr_r;
  logic signed [rcad_pkg::NUM_W-1:0] num_rssi, num_snr;
  logic        [rcad_pkg::DEN_W-1:0] den;
  logic                              busy_rssi, busy_snr;
  logic signed [7:0]                 q_rssi, q_snr;

  assign cnt_ext  = {{(rcad_pkg::NUM_W-16){1'b0}}, good_rx_r};
  assign rssi_ext = {{EXT_W{rssi_avg_r[7]}}, rssi_avg_r};
  assign snr_ext  = {{EXT_W{snr_avg_r[7]}}, snr_avg_r};
  assign num_rssi = prod_rssi_r + {{EXT_W{in_r.rssi_sample[7]}}, in_r.rssi_sample};
  assign num_snr  = prod_snr_r + {{EXT_W{in_r.snr_sample[7]}}, in_r.snr_sample};
  assign den      = {1'b0, good_rx_r} + rcad_pkg::DEN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.mul) begin
      prod_rssi_r <= rssi_ext * cnt_ext;
      prod_snr_r  <= snr_ext * cnt_ext;
    end
  end

  rcad_div u_div_rssi (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_rssi),
    .divisor  (den),
    .busy     (busy_rssi),
    .quotient (q_rssi)
  );

  rcad_div u_div_snr (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_snr),
    .divisor  (den),
    .busy     (busy_snr),
    .quotient (q_snr)
  );

  always_comb begin
    mode_nxt     = mode_r;
    cad_hit_nxt  = cad_hit_r;
    pending_nxt  = pending_r;
    win_over_nxt = win_over_r;
    rssi_avg_nxt = rssi_avg_r;
    snr_avg_nxt  = snr_avg_r;
    good_rx_nxt  = good_rx_r;
    tx_cnt_nxt   = tx_cnt_r;
    out_nxt      = '0;
    case (in_r.opcode)
      rcad_pkg::OP_POLL: begin
        case (mode_r)
          rcad_pkg::MODE_RXTIMEOUT: begin
            mode_nxt = rcad_pkg::MODE_STARTCAD;
          end
          rcad_pkg::MODE_RXERROR: begin
            pending_nxt = 1'b0;
            mode_nxt    = rcad_pkg::MODE_STARTCAD;
          end
          rcad_pkg::MODE_RX: begin
            if (pending_r) begin
              pending_nxt = 1'b0;
              good_rx_nxt = (good_rx_r + 16'd1) & rcad_pkg::COUNT_MASK;
              mode_nxt    = rcad_pkg::MODE_STARTCAD;
            end else begin
              if (cad_hit_r) begin
                win_over_nxt                = 1'b0;
                out_nxt.do_restart_rx_timer = 1'b1;
                out_nxt.do_start_rx         = 1'b1;
              end else begin
                out_nxt.do_arm_cad_timer = 1'b1;
              end
              mode_nxt = rcad_pkg::MODE_LOWPOWER;
            end
          end
          rcad_pkg::MODE_TX: begin
            tx_cnt_nxt      = (tx_cnt_r + 16'd1) & rcad_pkg::COUNT_MASK;
            out_nxt.do_send = 1'b1;
            mode_nxt        = rcad_pkg::MODE_LOWPOWER;
          end
          rcad_pkg::MODE_TXTIMEOUT: begin
            mode_nxt = rcad_pkg::MODE_LOWPOWER;
          end
          rcad_pkg::MODE_STARTCAD: begin
            out_nxt.do_stop_rx_timer = 1'b1;
            out_nxt.do_start_cad     = 1'b1;
            cad_hit_nxt              = 1'b0;
            mode_nxt                 = rcad_pkg::MODE_LOWPOWER;
          end
          default: begin
          end
        endcase
      end
      rcad_pkg::OP_TX_DONE: begin
        out_nxt.do_standby = 1'b1;
        mode_nxt           = rcad_pkg::MODE_TX;
      end
      rcad_pkg::OP_RX_DONE: begin
        out_nxt.do_standby = 1'b1;
        pending_nxt        = 1'b1;
        rssi_avg_nxt       = q_rssi;
        snr_avg_nxt        = q_snr;
        mode_nxt           = rcad_pkg::MODE_RX;
      end
      rcad_pkg::OP_TX_TIMEOUT: begin
        out_nxt.do_standby = 1'b1;
        mode_nxt           = rcad_pkg::MODE_TXTIMEOUT;
      end
      rcad_pkg::OP_RX_TIMEOUT: begin
        out_nxt.do_standby = 1'b1;
        if (win_over_r) begin
          mode_nxt = rcad_pkg::MODE_RXTIMEOUT;
        end else begin
          out_nxt.do_start_rx = 1'b1;
          mode_nxt            = rcad_pkg::MODE_LOWPOWER;
        end
      end
      rcad_pkg::OP_RX_ERROR: begin
        out_nxt.do_standby = 1'b1;
        mode_nxt           = rcad_pkg::MODE_RXERROR;
      end
      rcad_pkg::OP_CAD_DONE: begin
        out_nxt.do_standby = 1'b1;
        cad_hit_nxt        = in_r.activity_seen;
        mode_nxt           = rcad_pkg::MODE_RX;
      end
      rcad_pkg::OP_CAD_TIMER: begin
        out_nxt.do_standby = 1'b1;
        mode_nxt           = rcad_pkg::MODE_STARTCAD;
      end
      rcad_pkg::OP_RX_TIMER: begin
        win_over_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    out_nxt.mode_now      = mode_nxt;
    out_nxt.rssi_mean     = rssi_avg_nxt;
    out_nxt.snr_mean      = snr_avg_nxt;
    out_nxt.good_rx_total = good_rx_nxt;
    out_nxt.tx_total      = tx_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rcad_pkg::MODE_LOWPOWER;
      cad_hit_r   <= 1'b0;
      pending_r   <= 1'b0;
      win_over_r  <= 1'b0;
      rssi_avg_r  <= '0;
      snr_avg_r   <= '0;
      good_rx_r   <= '0;
      tx_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        mode_r      <= mode_nxt;
        cad_hit_r   <= cad_hit_nxt;
        pending_r   <= pending_nxt;
        win_over_r  <= win_over_nxt;
        rssi_avg_r  <= rssi_avg_nxt;
        snr_avg_r   <= snr_avg_nxt;
        good_rx_r   <= good_rx_nxt;
        tx_cnt_r    <= tx_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.is_rx    = (in_r.opcode == rcad_pkg::OP_RX_DONE);
  assign sts.div_busy = busy_rssi | busy_snr;
  assign sts.out_free = ~out_valid_r | out_ready;

endmodule

### src/rcad_ctrl.sv
// Controller: sequences accept, multiply, divide (rx done only) and commit of each word.
`include "assert_macros.svh"

module rcad_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcad_pkg::ctrl_sts_t  sts,
  output rcad_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   commit_stall;
  logic   stray_busy;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.is_rx ? ST_DIV_GO : ST_COMMIT;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign commit_stall = (state_r == ST_COMMIT) && !sts.out_free;
  assign stray_busy   = sts.div_busy && (state_r != ST_DIV_WAIT);

  `RCAD_ASSERT(a_div_starts, (state_r == ST_DIV_GO) |=> sts.div_busy, "divider idle after start")
  `RCAD_ASSERT(a_commit_waits, commit_stall |=> (state_r == ST_COMMIT), "commit left early")
  `RCAD_ASSERT_NEVER(a_busy_outside_div, stray_busy, "divider busy outside divide phase")

endmodule

### src/radio_cad_receive_controller_unit.sv
// Top level of the radio CAD / receive / transmit controller.
// Each accepted word is a radio event, timer expiry or dispatch poll and yields exactly one
// result word holding the command pulses, the mode after the step, the running signal
// strength and SNR means and the good-receive and transmit counters. Words other than
// rx done pass through the multiply and commit states after accept, and rx done also passes
// through the divide states, where the 25-step serial dividers update the two running means.
// A new word is accepted only once the previous one is committed, also while its result
// still waits in the output register; the next commit then stalls until that result is
// taken.
module radio_cad_receive_controller_unit (
  input logic       clk,
  input logic       rst_n,
  rcad_in_if.sink   in_word,
  rcad_out_if.source out_word
);

  rcad_pkg::ctrl_cmd_t cmd;
  rcad_pkg::ctrl_sts_t sts;

  rcad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcad_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_word.data),
    .out_ready (out_word.ready),
    .out_valid (out_word.valid),
    .out_data  (out_word.data)
  );

endmodule
